FILE: hw/rtl/htfd_pkg.sv
package htfd_pkg;

  localparam int TICK_W  = 16;
  localparam int FIELD_W = 15;
  localparam int PROD_W  = 31;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scale spans and offsets in hundredths
  localparam logic [FIELD_W-1:0] TEMP_SPAN   = 15'd17500;
  localparam logic [FIELD_W-1:0] TEMP_OFFSET = 15'd4500;
  localparam logic [FIELD_W-1:0] RH_SPAN     = 15'd12500;
  localparam logic [FIELD_W-1:0] RH_OFFSET   = 15'd600;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [TICK_W-1:0] temp_ticks;
    logic [TICK_W-1:0] hum_ticks;
    logic              ok;
  } htfd_job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/htfd_ifs.sv
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_out_if import htfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] temp_centi;
  logic signed [FIELD_W-1:0] rh_centi;
  logic                      ok;
  modport source (output valid, temp_centi, rh_centi, ok, input ready);
  modport sink   (input valid, temp_centi, rh_centi, ok, output ready);
endinterface

FILE: hw/rtl/humidity_temp_frame_decoder_top.sv
// Channel  Dir  Beat payload                              Accept
// in_ch    in   rx_byte[7:0], frame_start                 valid && ready
// out_ch   out  temp_centi[14:0] s, rh_centi[14:0] s, ok  valid && ready
//
// One byte beat per cycle sustained; the front takes a byte every cycle while
// the queue has room. After the sixth byte a result passes through the queue
// slot, the product register (two 16x15 multiplies) and the output register.
// Reset (rst_n low, synchronous) clears frame position, queue and valids.
// Output stall backs up into the two-entry queue; the front only stalls when
// the queue is full, so up to four results can be in flight.
module humidity_temp_frame_decoder_top import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  htfd_in_if.sink     in_ch,
  htfd_out_if.source  out_ch
);

  // Jobs from the byte tracker to the scaling pipeline
  logic      push_valid, push_ready;
  htfd_job_t push_job;
  logic      pop_valid, pop_ready;
  htfd_job_t pop_job;

  // Front: track frame position, run CRC, assemble words, emit one job per frame
  htfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decouple front and back so each can stall on its own
  htfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back: scale ticks to hundredths and drive the result beat
  htfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/htfd_front.sv
module htfd_front import htfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  htfd_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output htfd_job_t push_job
);

  typedef enum logic [2:0] {
    POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC
  } pos_t;

  pos_t              pos_r, pos_nxt, pos_eff;
  logic [7:0]        crc_r, crc_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [TICK_W-1:0] temp_r, temp_nxt;
  logic [TICK_W-1:0] hum_r, hum_nxt;
  logic              temp_good_r, temp_good_nxt;
  logic              accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_ch.frame_start) begin
      pos_eff = POS_T_HI;
    end else begin
      case (pos_r)
        POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC: pos_eff = pos_r;
        default: pos_eff = POS_T_HI;
      endcase
    end
  end

  assign push_valid          = in_ch.valid && (pos_eff == POS_H_CRC);
  assign push_job.temp_ticks = temp_r;
  assign push_job.hum_ticks  = hum_r;
  assign push_job.ok         = temp_good_r && (crc_r == in_ch.rx_byte);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hi_nxt        = hi_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    temp_good_nxt = temp_good_r;
    if (accept) begin
      case (pos_eff)
        POS_T_HI: begin
          crc_nxt = crc8_byte(CRC_INIT, in_ch.rx_byte);
          hi_nxt  = in_ch.rx_byte;
          pos_nxt = POS_T_LO;
        end
        POS_T_LO: begin
          crc_nxt  = crc8_byte(crc_r, in_ch.rx_byte);
          temp_nxt = {hi_r, in_ch.rx_byte};
          pos_nxt  = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_good_nxt = (crc_r == in_ch.rx_byte);
          pos_nxt       = POS_H_HI;
        end
        POS_H_HI: begin
          crc_nxt = crc8_byte(CRC_INIT, in_ch.rx_byte);
          hi_nxt  = in_ch.rx_byte;
          pos_nxt = POS_H_LO;
        end
        POS_H_LO: begin
          crc_nxt = crc8_byte(crc_r, in_ch.rx_byte);
          hum_nxt = {hi_r, in_ch.rx_byte};
          pos_nxt = POS_H_CRC;
        end
        default: begin
          pos_nxt = POS_T_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_T_HI;
    end else begin
      pos_r <= pos_nxt;
    end
    crc_r       <= crc_nxt;
    hi_r        <= hi_nxt;
    temp_r      <= temp_nxt;
    hum_r       <= hum_nxt;
    temp_good_r <= temp_good_nxt;
  end

endmodule

FILE: hw/rtl/htfd_queue.sv
module htfd_queue import htfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  htfd_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output htfd_job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  htfd_job_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/htfd_back.sv
module htfd_back import htfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  htfd_job_t pop_job,
  htfd_out_if.source out_ch
);

  logic                      s1_v_r, s1_v_nxt;
  logic [PROD_W-1:0]         temp_prod_r, rh_prod_r;
  logic                      s1_ok_r;
  logic                      out_v_r, out_v_nxt;
  logic signed [FIELD_W-1:0] temp_r, rh_r;
  logic                      ok_r;
  logic                      out_free;

  // floor(p / 65535) - off: with p = a*65536 + b, quotient is a plus one
  // when a + b reaches 65535 (a + b stays below twice the divisor).
  function automatic logic [FIELD_W-1:0] scale_div(input logic [PROD_W-1:0] p,
                                                   input logic [FIELD_W-1:0] off);
    logic [FIELD_W-1:0] a;
    logic [16:0]        sum;
    logic [FIELD_W-1:0] q;
    a   = p[PROD_W-1:16];
    sum = {2'b00, a} + {1'b0, p[15:0]};
    q   = a + FIELD_W'(sum >= 17'd65535);
    return q - off;
  endfunction

  assign out_free  = !out_v_r || out_ch.ready;
  assign pop_ready = !s1_v_r || out_free;
  assign s1_v_nxt  = pop_ready ? pop_valid : s1_v_r;
  assign out_v_nxt = out_free ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    if (pop_ready && pop_valid) begin
      temp_prod_r <= PROD_W'(pop_job.temp_ticks) * PROD_W'(TEMP_SPAN);
      rh_prod_r   <= PROD_W'(pop_job.hum_ticks) * PROD_W'(RH_SPAN);
      s1_ok_r     <= pop_job.ok;
    end
    if (out_free && s1_v_r) begin
      temp_r <= s1_ok_r ? scale_div(temp_prod_r, TEMP_OFFSET) : '0;
      rh_r   <= s1_ok_r ? scale_div(rh_prod_r, RH_OFFSET) : '0;
      ok_r   <= s1_ok_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.temp_centi = temp_r;
  assign out_ch.rh_centi   = rh_r;
  assign out_ch.ok         = ok_r;

`ifndef SYNTHESIS
  a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !ok_r) |-> (temp_r == '0 && rh_r == '0))
    else $error("failed frame carries nonzero values");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ok_r) |-> (temp_r >= -15'sd4500 && temp_r <= 15'sd13000))
    else $error("temperature out of range");

  a_rh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ok_r) |-> (rh_r >= -15'sd600 && rh_r <= 15'sd11900))
    else $error("humidity out of range");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> s1_v_r)
    else $error("product stage lost under stall");
`endif

endmodule

FILE: tb/sv/htfd_reading_checker.sv
module htfd_reading_checker import htfd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_frame_start,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [FIELD_W-1:0] out_temp_centi,
  input  logic signed [FIELD_W-1:0] out_rh_centi,
  input  logic                      out_ok,
  output int unsigned               outstanding,
  output int unsigned               mismatches
);

  localparam int unsigned TEMP_FULL  = 17500;
  localparam int unsigned TEMP_SHIFT = 4500;
  localparam int unsigned RH_FULL    = 12500;
  localparam int unsigned RH_SHIFT   = 600;
  localparam int unsigned TICK_MAX   = 65535;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic signed [FIELD_W-1:0] temp_centi;
    logic signed [FIELD_W-1:0] rh_centi;
    logic                      ok;
  } reading_t;

  // Frame tracking state
  logic [2:0]        frame_pos;
  logic [7:0]        word_crc;
  logic [7:0]        hi_byte;
  logic [TICK_W-1:0] t_ticks;
  logic [TICK_W-1:0] h_ticks;
  logic              t_good;

  reading_t    readings_due[$];
  int unsigned err_count = 0;

  // Shift the byte in MSB first against the 0x31 generator.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic signed [FIELD_W-1:0] ticks_to_centi(input logic [TICK_W-1:0] ticks,
                                                               input int unsigned full,
                                                               input int unsigned shift);
    logic [31:0] scaled;
    logic [31:0] diff;
    scaled = (full * 32'(ticks)) / TICK_MAX;
    diff   = scaled - shift;
    return diff[FIELD_W-1:0];
  endfunction

  task automatic clear_frame();
    frame_pos = 3'd0;
    word_crc  = 8'hFF;
    hi_byte   = 8'h00;
    t_ticks   = '0;
    h_ticks   = '0;
    t_good    = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [2:0] pos;
    reading_t   r;
    pos = fs ? 3'd0 : frame_pos;
    if (pos > 3'd5) pos = 3'd0;
    case (pos)
      3'd0, 3'd3: begin
        word_crc  = crc_step(8'hFF, b);
        hi_byte   = b;
        frame_pos = pos + 3'd1;
      end
      3'd1: begin
        word_crc  = crc_step(word_crc, b);
        t_ticks   = {hi_byte, b};
        frame_pos = 3'd2;
      end
      3'd2: begin
        t_good    = (word_crc == b);
        word_crc  = 8'hFF;
        frame_pos = 3'd3;
      end
      3'd4: begin
        word_crc  = crc_step(word_crc, b);
        h_ticks   = {hi_byte, b};
        frame_pos = 3'd5;
      end
      default: begin
        r.ok = t_good && (word_crc == b);
        if (r.ok) begin
          r.temp_centi = ticks_to_centi(t_ticks, TEMP_FULL, TEMP_SHIFT);
          r.rh_centi   = ticks_to_centi(h_ticks, RH_FULL, RH_SHIFT);
        end else begin
          r.temp_centi = '0;
          r.rh_centi   = '0;
        end
        word_crc  = 8'hFF;
        frame_pos = 3'd0;
        readings_due.push_back(r);
      end
    endcase
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    err_count++;
    if (err_count <= REPORT_MAX)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    reading_t seen;
    reading_t want;
    if (!rst_n) begin
      clear_frame();
      readings_due.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_rx_byte, in_frame_start);
      if (out_valid && out_ready) begin
        seen = '{out_temp_centi, out_rh_centi, out_ok};
        if (readings_due.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: unexpected reading temp %0d rh %0d ok %0b", $time,
                     seen.temp_centi, seen.rh_centi, seen.ok);
        end else begin
          want = readings_due.pop_front();
          if (seen.temp_centi !== want.temp_centi)
            flag_field("temp_centi", int'(want.temp_centi), int'(seen.temp_centi));
          if (seen.rh_centi !== want.rh_centi)
            flag_field("rh_centi", int'(want.rh_centi), int'(seen.rh_centi));
          if (seen.ok !== want.ok)
            flag_field("ok", int'(want.ok), int'(seen.ok));
        end
      end
    end
    outstanding <= readings_due.size();
    mismatches  <= err_count;
  end

endmodule

FILE: tb/sv/tb_humidity_temp_frame_decoder_top.sv
module tb_humidity_temp_frame_decoder_top import htfd_pkg::*; ();

  // Generous bound: ~1700 beats, worst phase idles 82% of cycles.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned PHASE_BEATS  = 420;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  htfd_in_if  in_ch();
  htfd_out_if out_ch();

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned cycle_count  = 0;
  int unsigned beats_sent   = 0;
  int unsigned send_idle    = 0;  // percent of cycles the sender holds off
  int unsigned recv_stall   = 0;  // percent of cycles the receiver stalls
  bit          need_start   = 1'b1;

  humidity_temp_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  htfd_reading_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_rx_byte     (in_ch.rx_byte),
    .in_frame_start (in_ch.frame_start),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_temp_centi (out_ch.temp_centi),
    .out_rh_centi   (out_ch.rh_centi),
    .out_ok         (out_ch.ok),
    .outstanding    (outstanding),
    .mismatches     (mismatches)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Randomly stall the result side; one draw per cycle.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one byte beat: idle at random first, then hold valid until accepted.
  task automatic push_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Build a frame with correct CRCs, optionally corrupt either CRC byte,
  // and send its first n_bytes beats; frame_start rides on the first one.
  task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs,
                            input logic [7:0] t_flip, input logic [7:0] h_flip,
                            input int n_bytes);
    logic [7:0] frame [6];
    frame[0] = t[15:8];
    frame[1] = t[7:0];
    frame[2] = crc8_byte(crc8_byte(CRC_INIT, t[15:8]), t[7:0]) ^ t_flip;
    frame[3] = h[15:8];
    frame[4] = h[7:0];
    frame[5] = crc8_byte(crc8_byte(CRC_INIT, h[15:8]), h[7:0]) ^ h_flip;
    for (int i = 0; i < n_bytes; i++) push_byte(frame[i], (i == 0) ? fs : 1'b0);
  endtask

  function automatic logic [15:0] pick_ticks();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // One random sequence: mostly clean frames, some bad CRCs, some
  // truncated frames and some raw noise bytes.
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    logic        fs;
    pick = $urandom_range(99);
    fs   = need_start ? 1'b1 : ($urandom_range(3) != 0);
    if (pick < 70) begin
      send_frame(pick_ticks(), pick_ticks(), fs, 8'h00, 8'h00, 6);
      need_start = 1'b0;
    end else if (pick < 80) begin
      send_frame(pick_ticks(), pick_ticks(), fs, 8'($urandom_range(255, 1)), 8'h00, 6);
      need_start = 1'b0;
    end else if (pick < 88) begin
      send_frame(pick_ticks(), pick_ticks(), fs, 8'h00, 8'($urandom_range(255, 1)), 6);
      need_start = 1'b0;
    end else if (pick < 95) begin
      send_frame(pick_ticks(), pick_ticks(), fs, 8'h00, 8'h00, $urandom_range(5, 1));
      need_start = 1'b1;
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) push_byte(8'($urandom), 1'($urandom));
      need_start = 1'b1;
    end
  endtask

  initial begin
    int unsigned idle_pct  [4];
    int unsigned stall_pct [4];
    int unsigned goal;
    idle_pct  = '{0, 82, 0, 33};
    stall_pct = '{0, 0, 82, 33};
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = 8'h00;
    in_ch.frame_start = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coldest and driest, then hottest and wettest back to back
    // without a frame start, since the position wraps after the sixth byte.
    send_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00, 6);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00, 6);
    // Drop a partial frame: restart with frame start after three bytes,
    // and give the restarted frame a broken temperature CRC.
    send_frame(16'h6666, 16'h8000, 1'b1, 8'h00, 8'h00, 3);
    send_frame(16'hBEEF, 16'h1234, 1'b1, 8'hFF, 8'h00, 6);
    // Good temperature, broken humidity CRC.
    send_frame(16'h1234, 16'hBEEF, 1'b0, 8'h00, 8'h01, 6);

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int p = 0; p < 4; p++) begin
      send_idle  = idle_pct[p];
      recv_stall = stall_pct[p];
      goal       = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) random_sequence();
    end
    in_ch.valid <= 1'b0;
    send_idle   = 0;
    recv_stall  = 0;

    // Drain, then give the pipeline a few more cycles to show strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
